// ===== rtl/core/itap_pkg.sv =====
// Package: shared types, codes and character helpers of the IPv6 text parser.
package itap_pkg;

    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_ERROR = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [8:0] {
        PH_START      = 9'b000000001,
        PH_GSTART     = 9'b000000010,
        PH_AFTERCOLON = 9'b000000100,
        PH_GZERO      = 9'b000001000,
        PH_GX         = 9'b000010000,
        PH_GDIGITS    = 9'b000100000,
        PH_V4TAIL     = 9'b001000000,
        PH_V4ONLY     = 9'b010000000,
        PH_DONE       = 9'b100000000
    } phase_t;

    typedef enum logic [5:0] {
        VP_START = 6'b000001,
        VP_ZERO  = 6'b000010,
        VP_X     = 6'b000100,
        VP_NUM   = 6'b001000,
        VP_OK    = 6'b010000,
        VP_ERR   = 6'b100000
    } vphase_t;

    // Character class decoded by the front end.
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] family;
        logic       is_nul;
        logic       is_colon;
        logic       is_dot;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_dec;
        logic       is_alnum;
        logic       is_space;
        logic       is_x;
    } cls_t;

    localparam int CLS_W = $bits(cls_t);

    function automatic cls_t classify(input logic [7:0] c, input logic [1:0] fam);
        cls_t r;
        r.ch       = c;
        r.family   = fam;
        r.is_nul   = (c == CH_NUL);
        r.is_colon = (c == CH_COLON);
        r.is_dot   = (c == CH_DOT);
        r.is_dec   = (c >= 8'h30 && c <= 8'h39);
        r.is_x     = (c == 8'h78 || c == 8'h58);
        r.hex_val  = 4'd0;
        r.is_hex   = 1'b0;
        if (r.is_dec) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h37);
        end
        r.is_alnum = r.is_dec || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
        r.is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
        return r;
    endfunction

endpackage

// ===== rtl/core/ipv6_text_address_parser.sv =====
// Top level of the IPv6/IPv4 text address parser.
//
//   channel   direction  ports
//   s_        in         s_character, s_family, s_valid, s_ready
//   m_        out        m_status, m_address_high, m_address_low, m_valid, m_ready
//
// One character per cycle sustained unless a result waits on m_ready; the parse state machine updates in one step.
// A result passes from its NUL transfer through the front register, then the queue,
// then the parse into the result register.
// Reset clears all control state; a new string starts after reset.
// A stalled result holds the back end; the queue and front register still take
// up to three more characters before s_ready drops.
module ipv6_text_address_parser
    import itap_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_character,
    input  logic [1:0]  s_family,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low,
    output logic        m_valid,
    input  logic        m_ready
);

    cls_t f_data, b_data;
    logic f_valid, f_ready, b_valid, b_ready;

    itap_front u_front (
        .aclk, .aresetn, .s_character, .s_family, .s_valid, .s_ready,
        .q_data(f_data), .q_valid(f_valid), .q_ready(f_ready)
    );

    itap_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk, .aresetn,
        .in_data(f_data), .in_valid(f_valid), .in_ready(f_ready),
        .out_data(b_data), .out_valid(b_valid), .out_ready(b_ready)
    );

    itap_back u_back (
        .aclk, .aresetn, .q_data(b_data), .q_valid(b_valid), .q_ready(b_ready),
        .m_status, .m_address_high, .m_address_low, .m_valid, .m_ready
    );

endmodule

// ===== rtl/core/itap_front.sv =====
// Front end: accepts characters, classifies them, and feeds the queue.
module itap_front
    import itap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_character,
    input  logic [1:0]  s_family,
    input  logic        s_valid,
    output logic        s_ready,
    output cls_t        q_data,
    output logic        q_valid,
    input  logic        q_ready
);

    cls_t data_reg;
    logic valid_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_data  = data_reg;
    assign q_valid = valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= classify(s_character, s_family);
        end
    end

endmodule

// ===== rtl/core/itap_queue.sv =====
// Short queue between front and back end.
module itap_queue
    import itap_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  cls_t in_data,
    input  logic in_valid,
    output logic in_ready,
    output cls_t out_data,
    output logic out_valid,
    input  logic out_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cls_t            mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != (PW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= inc(wp_reg);
            if (pop)  rp_reg <= inc(rp_reg);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_data;
    end

endmodule

// ===== rtl/core/itap_back.sv =====
// Back end: parse state machine, address assembly and result register.
module itap_back
    import itap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cls_t        q_data,
    input  logic        q_valid,
    output logic        q_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_address_high,
    output logic [63:0] m_address_low,
    output logic        m_valid,
    input  logic        m_ready
);

    logic [7:0]  ab_reg [16];
    logic [7:0]  ab_next [16];
    logic [16:0] gv_reg, gv_next;
    logic [4:0]  bp_reg, bp_next;
    logic [4:0]  ep_reg, ep_next;
    phase_t      ph_reg, ph_next;
    logic        v4map_reg, v4map_next;
    logic        elided_reg, elided_next;
    logic [32:0] pv_reg, pv_next;
    logic [31:0] parts_reg, parts_next;
    vphase_t     vp_reg, vp_next;
    logic [4:0]  base_reg, base_next;
    logic [1:0]  vc_reg, vc_next;
    logic [2:0]  vcnt_reg, vcnt_next;
    logic [1:0]  rs_reg, rs_next;

    logic        out_valid_reg;
    logic [1:0]  out_st_reg;
    logic [63:0] out_hi_reg, out_lo_reg;
    logic [1:0]  out_st_next;
    logic [63:0] out_hi_next, out_lo_next;

    logic step;
    cls_t c;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;
    assign c       = q_data;

    assign m_valid        = out_valid_reg;
    assign m_status       = out_st_reg;
    assign m_address_high = out_hi_reg;
    assign m_address_low  = out_lo_reg;

    always_comb begin
        logic [7:0]  tmp [16];
        logic [4:0]  i, e;
        logic        ends_grp, dgt_ok;
        logic [3:0]  dval;
        logic [36:0] prod;
        logic [32:0] maxv;
        logic [63:0] sh;
        logic        do_v4feed, do_tail, do_succeed, do_fail, do_store;
        logic        do_v4only, do_restart;
        logic [1:0]  st;

        for (int k = 0; k < 16; k++) ab_next[k] = ab_reg[k];
        gv_next = gv_reg; bp_next = bp_reg; ep_next = ep_reg; ph_next = ph_reg;
        v4map_next = v4map_reg; elided_next = elided_reg; pv_next = pv_reg;
        parts_next = parts_reg; vp_next = vp_reg; base_next = base_reg;
        vcnt_next = vcnt_reg; vc_next = vc_reg; rs_next = rs_reg;
        do_v4feed = 1'b0; do_tail = 1'b0; do_succeed = 1'b0; do_fail = 1'b0;
        do_store = 1'b0; do_v4only = 1'b0; do_restart = 1'b0;
        ends_grp = !(c.is_colon || c.is_alnum);
        dgt_ok = 1'b0; dval = 4'd0; prod = '0; maxv = '0; sh = '0;
        i = '0; e = '0; st = ST_ERROR;
        for (int k = 0; k < 16; k++) tmp[k] = 8'd0;

        unique case (ph_reg)
            PH_START: begin
                vc_next = c.family;
                if (c.family == FAM_V6) begin
                    if (bp_reg >= 5'd16 || !(c.is_colon || c.is_hex)) begin
                        do_fail = 1'b1;
                    end else if (c.is_colon) begin
                        gv_next = '0; do_store = 1'b1; v4map_next = 1'b0;
                        ph_next = PH_AFTERCOLON;
                    end else begin
                        gv_next = 17'(c.hex_val);
                        do_restart = 1'b1; do_v4feed = 1'b1;
                        ph_next = (c.ch == 8'h30) ? PH_GZERO : PH_GDIGITS;
                    end
                end else if (c.family == FAM_V4) begin
                    do_restart = 1'b1; do_v4feed = 1'b1; do_v4only = 1'b1;
                    ph_next = PH_V4ONLY;
                end else begin
                    rs_next = ST_UNSUP; ph_next = PH_DONE;
                end
            end
            PH_GSTART, PH_AFTERCOLON: begin
                if (ph_reg == PH_AFTERCOLON && c.is_colon) begin
                    if (elided_reg) do_fail = 1'b1;
                    else begin
                        elided_next = 1'b1; ep_next = bp_reg; ph_next = PH_GSTART;
                    end
                end else if (bp_reg >= 5'd16 || !(c.is_colon || c.is_hex)) begin
                    if (!ends_grp) do_fail = 1'b1;
                    else do_succeed = 1'b1;
                end else if (c.is_colon) begin
                    gv_next = '0; do_store = 1'b1; v4map_next = 1'b0;
                    ph_next = PH_AFTERCOLON;
                end else begin
                    gv_next = 17'(c.hex_val);
                    do_restart = 1'b1; do_v4feed = 1'b1;
                    ph_next = (c.ch == 8'h30) ? PH_GZERO : PH_GDIGITS;
                end
            end
            PH_GX: begin
                if (c.is_hex) begin
                    gv_next = 17'(c.hex_val); do_v4feed = 1'b1; ph_next = PH_GDIGITS;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_GZERO, PH_GDIGITS: begin
                if (ph_reg == PH_GZERO && c.is_x) begin
                    do_v4feed = 1'b1; ph_next = PH_GX;
                end else begin
                    ph_next = PH_GDIGITS;
                    if (c.is_hex) begin
                        gv_next = ({gv_reg[12:0], 4'd0} | 17'(c.hex_val));
                        if (gv_reg[16:12] != 5'd0) gv_next = 17'h10000;
                        do_v4feed = 1'b1;
                    end else if (c.is_dot || (c.is_nul && bp_reg == 5'd0)) begin
                        if (bp_reg > 5'd12) do_fail = 1'b1;
                        else begin
                            do_v4feed = 1'b1; ph_next = PH_V4TAIL; do_tail = 1'b1;
                        end
                    end else if (gv_reg[16] || (!c.is_colon && !ends_grp)) begin
                        do_fail = 1'b1;
                    end else begin
                        do_store = 1'b1;
                        if (c.is_colon) begin
                            v4map_next = 1'b0; ph_next = PH_AFTERCOLON;
                        end else begin
                            do_succeed = 1'b1;
                        end
                    end
                end
            end
            PH_V4TAIL: begin
                do_v4feed = 1'b1; do_tail = 1'b1;
            end
            PH_V4ONLY: begin
                do_v4feed = 1'b1; do_v4only = 1'b1;
            end
            PH_DONE: ;
            default: ;
        endcase

        // IPv4 sub-parse
        if (do_restart) begin
            vp_next = VP_START; base_next = 5'd10; vcnt_next = '0;
            pv_next = '0; parts_next = '0;
        end
        if (do_v4feed) begin
            unique case (vp_next)
                VP_START: begin
                    if (c.is_dec) begin
                        pv_next = 33'(c.hex_val); base_next = 5'd10;
                        vp_next = (c.ch == 8'h30) ? VP_ZERO : VP_NUM;
                    end else vp_next = VP_ERR;
                end
                VP_X: begin
                    if (c.is_hex) begin
                        pv_next = 33'(c.hex_val); base_next = 5'd16; vp_next = VP_NUM;
                    end else vp_next = VP_ERR;
                end
                VP_ZERO, VP_NUM: begin
                    if (vp_next == VP_ZERO && c.is_x) begin
                        vp_next = VP_X;
                    end else begin
                        if (vp_next == VP_ZERO) base_next = 5'd8;
                        vp_next = VP_NUM;
                        if (base_next == 5'd16) begin
                            dgt_ok = c.is_hex; dval = c.hex_val;
                        end else begin
                            dgt_ok = c.is_dec && (base_next == 5'd10 || c.hex_val < 4'd8);
                            dval = c.hex_val;
                        end
                        if (dgt_ok) begin
                            unique case (base_next)
                                5'd16: prod = {pv_next, 4'd0};
                                5'd8:  prod = {1'b0, pv_next, 3'd0};
                                default: prod = {pv_next, 3'd0} + {2'b0, pv_next, 1'b0};
                            endcase
                            prod = prod + 37'(dval);
                            pv_next = (prod > 37'h100000000) ? 33'h100000000 : prod[32:0];
                        end else if (c.is_dot) begin
                            if (vcnt_next >= 3'd3 || pv_next > 33'hff) vp_next = VP_ERR;
                            else begin
                                parts_next = {parts_next[23:0], pv_next[7:0]};
                                vcnt_next = vcnt_next + 3'd1; vp_next = VP_START;
                            end
                        end else if (c.is_nul || c.is_space) begin
                            maxv = 33'({32'hffffffff} >> (8 * vcnt_next[1:0]));
                            if (pv_next > maxv) vp_next = VP_ERR;
                            else begin
                                sh = {32'd0, parts_next} << (8 * (3'd4 - {1'b0, vcnt_next[1:0]}));
                                parts_next = sh[31:0] | pv_next[31:0];
                                vp_next = VP_OK;
                            end
                        end else vp_next = VP_ERR;
                    end
                end
                default: ;
            endcase
        end

        if (do_store) begin
            ab_next[bp_next[3:0]]        = gv_next[15:8];
            ab_next[4'(bp_next + 5'd1)]  = gv_next[7:0];
            bp_next = bp_next + 5'd2;
        end
        if (do_tail) begin
            if (vp_next == VP_OK && bp_next <= 5'd12) begin
                ab_next[bp_next[3:0]]       = parts_next[31:24];
                ab_next[4'(bp_next + 5'd1)] = parts_next[23:16];
                ab_next[4'(bp_next + 5'd2)] = parts_next[15:8];
                ab_next[4'(bp_next + 5'd3)] = parts_next[7:0];
                bp_next = bp_next + 5'd4;
                do_succeed = 1'b1;
            end else if (vp_next == VP_ERR || vp_next == VP_OK) begin
                do_fail = 1'b1;
            end
        end
        if (do_v4only) begin
            if (vp_next == VP_OK) begin
                ab_next[12] = parts_next[31:24]; ab_next[13] = parts_next[23:16];
                ab_next[14] = parts_next[15:8];  ab_next[15] = parts_next[7:0];
                rs_next = ST_OK; ph_next = PH_DONE;
            end else if (vp_next == VP_ERR) do_fail = 1'b1;
        end
        if (do_succeed) begin
            // move tail bytes behind the elision to the end, zero the gap
            i = (bp_next > 5'd16) ? 5'd16 : bp_next;
            e = elided_next ? ep_next : 5'd0;
            if (e > i) e = i;
            for (int k = 0; k < 16; k++) begin
                if (5'(k) < e) tmp[k] = ab_next[k];
                else if (5'(k) < e + 5'd16 - i) tmp[k] = 8'd0;
                else tmp[k] = ab_next[4'(5'(k) - 5'd16 + i)];
            end
            for (int k = 0; k < 16; k++) ab_next[k] = tmp[k];
            if (v4map_next) begin
                ab_next[10] = 8'hff; ab_next[11] = 8'hff;
            end
            rs_next = ST_OK; ph_next = PH_DONE;
        end
        if (do_fail) begin
            rs_next = ST_ERROR; ph_next = PH_DONE;
        end
        st = (ph_next == PH_DONE) ? rs_next : ST_ERROR;
        out_st_next = st;
        for (int k = 0; k < 8; k++) begin
            out_hi_next[63-8*k -: 8] = ab_next[k];
            out_lo_next[63-8*k -: 8] = ab_next[k+8];
        end
        if (st != ST_OK) begin
            out_hi_next = '0; out_lo_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && c.is_nul)) begin
            for (int k = 0; k < 16; k++) ab_reg[k] <= 8'd0;
            gv_reg <= '0; bp_reg <= '0; ep_reg <= '0; ph_reg <= PH_START;
            v4map_reg <= 1'b1; elided_reg <= 1'b0; pv_reg <= '0; parts_reg <= '0;
            vp_reg <= VP_START; base_reg <= 5'd10; vcnt_reg <= '0; vc_reg <= '0;
            rs_reg <= ST_ERROR;
        end else if (step) begin
            for (int k = 0; k < 16; k++) ab_reg[k] <= ab_next[k];
            gv_reg <= gv_next; bp_reg <= bp_next; ep_reg <= ep_next; ph_reg <= ph_next;
            v4map_reg <= v4map_next; elided_reg <= elided_next; pv_reg <= pv_next;
            parts_reg <= parts_next; vp_reg <= vp_next; base_reg <= base_next;
            vcnt_reg <= vcnt_next; vc_reg <= vc_next; rs_reg <= rs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_ready) begin
            out_valid_reg <= step && c.is_nul;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && c.is_nul) begin
            out_st_reg <= out_st_next;
            out_hi_reg <= out_hi_next;
            out_lo_reg <= out_lo_next;
        end
    end

endmodule

// ===== tb/ipv6_text_address_checker.sv =====
// Checker: predicts parser results from the accepted characters and compares them.
module ipv6_text_address_checker
    import itap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_character,
    input  logic [1:0]  s_family,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  m_status,
    input  logic [63:0] m_address_high,
    input  logic [63:0] m_address_low,
    input  logic        m_valid,
    input  logic        m_ready,
    output int          error_count,
    output int          pending_count,
    output int          result_count,
    output int          ok_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] high;
        logic [63:0] low;
    } parse_result_t;

    parse_result_t expected_results[$];

    logic [7:0]  addr [16];
    logic [16:0] grp;
    int          bpos;
    int          epos;
    phase_t      phase;
    bit          v4map;
    bit          elided;
    logic [33:0] part;
    logic [31:0] parts;
    vphase_t     vph;
    int          vbase;
    int          vcount;
    logic [1:0]  decided;

    function automatic int hexval(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit spc(logic [7:0] c);
        return c == " " || (c >= 9 && c <= 13);
    endfunction

    function automatic bit delim(logic [7:0] c);
        return !(c == CH_COLON || alnum(c));
    endfunction

    task automatic clear_state();
        foreach (addr[k]) addr[k] = 8'h00;
        grp = '0; bpos = 0; epos = 0; phase = PH_START;
        v4map = 1; elided = 0; decided = ST_ERROR;
        v4_restart();
    endtask

    task automatic v4_restart();
        vph = VP_START; vbase = 10; vcount = 0; part = '0; parts = '0;
    endtask

    task automatic v4_char(logic [7:0] c);
        int d;
        logic [33:0] maxv;
        logic [63:0] wide;
        if (vph == VP_START) begin
            if (c >= "0" && c <= "9") begin
                part = 34'(c - "0"); vbase = 10;
                vph = (c == "0") ? VP_ZERO : VP_NUM;
            end else vph = VP_ERR;
            return;
        end
        if (vph == VP_X) begin
            d = hexval(c);
            if (d >= 0) begin
                part = 34'(d); vbase = 16; vph = VP_NUM;
            end else vph = VP_ERR;
            return;
        end
        if (vph == VP_ZERO) begin
            if (c == "x" || c == "X") begin
                vph = VP_X;
                return;
            end
            vbase = 8; vph = VP_NUM;
        end
        if (vph != VP_NUM) return;
        if (vbase == 16) d = hexval(c);
        else if (c >= "0" && c < "0" + vbase) d = c - "0";
        else d = -1;
        if (d >= 0) begin
            wide = 64'(part) * 64'(vbase) + 64'(d);
            part = (wide > 64'h1_0000_0000) ? 34'h1_0000_0000 : wide[33:0];
            return;
        end
        if (c == CH_DOT) begin
            if (vcount >= 3 || part > 34'hff) vph = VP_ERR;
            else begin
                parts = (parts << 8) | part[31:0];
                vcount++; vph = VP_START;
            end
        end else if (c == CH_NUL || spc(c)) begin
            maxv = 34'hffff_ffff >> (8 * (vcount & 3));
            if (part > maxv) vph = VP_ERR;
            else begin
                wide = (64'(parts) << (8 * (4 - (vcount & 3)))) | 64'(part);
                parts = wide[31:0]; vph = VP_OK;
            end
        end else vph = VP_ERR;
    endtask

    task automatic reject();
        decided = ST_ERROR; phase = PH_DONE;
    endtask

    task automatic v6_accept();
        logic [7:0] tmp [16];
        int i, e;
        i = bpos > 16 ? 16 : bpos;
        e = elided ? epos : 0;
        if (e > i) e = i;
        if (i < 16) begin
            tmp = addr;
            for (int k = 0; k < i - e; k++) addr[e + 16 - i + k] = tmp[e + k];
            for (int k = 0; k < 16 - i; k++) addr[e + k] = 8'h00;
        end
        if (v4map) begin
            addr[10] = 8'hff; addr[11] = 8'hff;
        end
        decided = ST_OK; phase = PH_DONE;
    endtask

    task automatic store_group();
        addr[bpos & 15] = grp[15:8];
        addr[(bpos + 1) & 15] = grp[7:0];
        bpos += 2;
    endtask

    task automatic group_open(logic [7:0] c, bit first);
        int d;
        d = hexval(c);
        if (bpos >= 16 || !(c == CH_COLON || d >= 0)) begin
            if (first || !delim(c)) reject();
            else v6_accept();
            return;
        end
        if (c == CH_COLON) begin
            grp = '0; store_group(); v4map = 0; phase = PH_AFTERCOLON;
            return;
        end
        grp = 17'(d);
        v4_restart();
        v4_char(c);
        phase = (c == "0") ? PH_GZERO : PH_GDIGITS;
    endtask

    task automatic tail_check();
        if (vph == VP_OK && bpos <= 12) begin
            for (int k = 0; k < 4; k++) addr[bpos + k] = parts[31 - 8 * k -: 8];
            bpos += 4;
            v6_accept();
        end else if (vph == VP_ERR || vph == VP_OK) reject();
    endtask

    task automatic group_digit(logic [7:0] c);
        int d;
        d = hexval(c);
        if (d >= 0) begin
            grp = (grp * 16 + d > 17'h10000) ? 17'h10000 : 17'(grp * 16 + d);
            v4_char(c);
            return;
        end
        if (c == CH_DOT || (c == CH_NUL && bpos == 0)) begin
            if (bpos > 12) begin
                reject();
                return;
            end
            v4_char(c);
            phase = PH_V4TAIL;
            tail_check();
            return;
        end
        if (grp > 17'hffff || (c != CH_COLON && !delim(c))) begin
            reject();
            return;
        end
        store_group();
        if (c == CH_COLON) begin
            v4map = 0; phase = PH_AFTERCOLON;
        end else v6_accept();
    endtask

    task automatic v4_only(logic [7:0] c);
        v4_char(c);
        if (vph == VP_OK) begin
            for (int k = 0; k < 4; k++) addr[12 + k] = parts[31 - 8 * k -: 8];
            decided = ST_OK; phase = PH_DONE;
        end else if (vph == VP_ERR) reject();
    endtask

    task automatic parse_char(logic [7:0] c, logic [1:0] fam);
        parse_result_t r;
        case (phase)
            PH_START: begin
                if (fam == FAM_V6) group_open(c, 1);
                else if (fam == FAM_V4) begin
                    phase = PH_V4ONLY;
                    v4_restart();
                    v4_only(c);
                end else begin
                    decided = ST_UNSUP; phase = PH_DONE;
                end
            end
            PH_GSTART: group_open(c, 0);
            PH_AFTERCOLON: begin
                if (c == CH_COLON) begin
                    if (elided) reject();
                    else begin
                        elided = 1; epos = bpos; phase = PH_GSTART;
                    end
                end else group_open(c, 0);
            end
            PH_GZERO: begin
                if (c == "x" || c == "X") begin
                    v4_char(c); phase = PH_GX;
                end else begin
                    phase = PH_GDIGITS; group_digit(c);
                end
            end
            PH_GX: begin
                if (hexval(c) >= 0) begin
                    grp = 17'(hexval(c)); v4_char(c); phase = PH_GDIGITS;
                end else reject();
            end
            PH_GDIGITS: group_digit(c);
            PH_V4TAIL: begin
                v4_char(c); tail_check();
            end
            PH_V4ONLY: v4_only(c);
            default: ;
        endcase
        if (c != CH_NUL) return;
        r.status = (phase == PH_DONE) ? decided : ST_ERROR;
        r.high = '0;
        r.low = '0;
        if (r.status == ST_OK)
            for (int k = 0; k < 8; k++) begin
                r.high = (r.high << 8) | 64'(addr[k]);
                r.low = (r.low << 8) | 64'(addr[k + 8]);
            end
        expected_results.push_back(r);
        clear_state();
    endtask

    initial begin
        error_count = 0; result_count = 0; ok_count = 0; pending_count = 0;
        clear_state();
    end

    always @(posedge aclk) begin
        parse_result_t want;
        int errs;
        errs = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result");
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    result_count <= result_count + 1;
                    if (want.status == ST_OK) ok_count <= ok_count + 1;
                    if (m_status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, m_status);
                        errs++;
                    end
                    if (m_address_high !== want.high) begin
                        $error("address_high: expected %h actual %h", want.high,
                               m_address_high);
                        errs++;
                    end
                    if (m_address_low !== want.low) begin
                        $error("address_low: expected %h actual %h", want.low,
                               m_address_low);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) parse_char(s_character, s_family);
        end
        if (errs != 0) error_count <= error_count + errs;
        pending_count <= expected_results.size();
    end
endmodule

// ===== tb/tb_ipv6_text_address_parser.sv =====
// Testbench top: drives address text strings into the parser and gives the verdict.
module tb_ipv6_text_address_parser;
    import itap_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic [7:0]  s_character = 0;
    logic [1:0]  s_family = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  m_status;
    logic [63:0] m_address_high, m_address_low;
    logic        m_valid;
    logic        m_ready = 0;
    int          error_count, pending_count, result_count, ok_count;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    int          chars_sent = 0;
    int          quiet_cycles = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    ipv6_text_address_parser u_dut (.*);

    ipv6_text_address_checker u_checker (.*);

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hold each character until its transfer, with random gaps before it.
    task automatic send_char(logic [7:0] c, logic [1:0] fam);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_character <= c;
        s_family <= fam;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(string t, logic [1:0] fam);
        for (int k = 0; k < t.len(); k++) send_char(t[k], fam);
        send_char(CH_NUL, fam);
    endtask

    function automatic string hex_group();
        string s;
        int n;
        n = $urandom_range(4, 1);
        if ($urandom_range(19) == 0) n = 5;
        s = ($urandom_range(9) == 0) ? "0x" : "";
        for (int k = 0; k < n; k++) s = {s, $sformatf("%h", 4'($urandom))};
        if ($urandom_range(3) == 0) s = s.toupper();
        return s;
    endfunction

    function automatic string dotted();
        string s;
        int n;
        n = $urandom_range(4, 1);
        s = "";
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0: s = {s, $sformatf("0x%h", 8'($urandom))};
                1: s = {s, $sformatf("0%o", 8'($urandom))};
                2: s = {s, $sformatf("%0d", $urandom)};
                default: s = {s, $sformatf("%0d", $urandom_range(255))};
            endcase
            if (k < n - 1) s = {s, "."};
        end
        return s;
    endfunction

    function automatic string v6_text();
        string s;
        int n, gap;
        n = $urandom_range(8, 1);
        gap = ($urandom_range(2) == 0) ? -1 : $urandom_range(n);
        s = "";
        for (int k = 0; k < n; k++) begin
            if (k == gap) s = {s, "::"};
            else if (k > 0) s = {s, ":"};
            s = {s, hex_group()};
        end
        if (gap == n) s = {s, "::"};
        if ($urandom_range(5) == 0) s = {s, ":", dotted()};
        if ($urandom_range(9) == 0) s = {s, " tail"};
        return s;
    endfunction

    function automatic string noisy(string s);
        int n;
        if (s.len() == 0) return s;
        n = $urandom_range(s.len() - 1);
        case ($urandom_range(3))
            0: s[n] = 8'($urandom_range(255, 1));
            1: s[n] = ":";
            2: s[n] = ".";
            default: s = s.substr(0, n);
        endcase
        return s;
    endfunction

    task automatic random_string();
        string s;
        logic [1:0] fam;
        int r;
        r = $urandom_range(99);
        fam = (r < 60) ? FAM_V6 : (r < 90) ? FAM_V4 : 2'($urandom_range(3, 2));
        s = (fam == FAM_V4) ? dotted() : v6_text();
        if ($urandom_range(3) == 0) s = noisy(s);
        send_text(s, fam);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_idle_pct = 34; recv_idle_pct = 67;
        send_text("::", FAM_V6);
        send_text("::1", FAM_V6);
        send_text("ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", FAM_V6);
        send_text("1:2:3:4:5:6:7:8:9", FAM_V6);
        send_text("1:2:3:4:5:6:7:8 junk", FAM_V6);
        send_text("1::2::3", FAM_V6);
        send_text("10000::", FAM_V6);
        send_text("0x12:0X:1", FAM_V6);
        send_text("0xAB::1", FAM_V6);
        send_text("12g4::1", FAM_V6);
        send_text("1234", FAM_V6);
        send_text("127.0.0.1", FAM_V6);
        send_text("::ffff:192.168.1.1", FAM_V6);
        send_text("1:2:3:4:5:6:7:1.2.3.4", FAM_V6);
        send_text("1:2:3:4:5:6:1.2.3.4", FAM_V6);
        send_text("", FAM_V6);
        send_text("x1", FAM_V6);
        send_text("255.255.255.255", FAM_V4);
        send_text("0x7f.1", FAM_V4);
        send_text("0377.0.0.0 ", FAM_V4);
        send_text("4294967296", FAM_V4);
        send_text("256.1.1.1", FAM_V4);
        send_text("1.2.3.4.5", FAM_V4);
        send_text("1.2.3", 2'd2);
        send_text("\xff\x80", 2'd3);

        while (chars_sent < 600) random_string();
        send_idle_pct = 67; recv_idle_pct = 34;
        while (chars_sent < 1200) random_string();
        send_idle_pct = 0; recv_idle_pct = 0;
        while (chars_sent < 1800) random_string();
        s_valid <= 0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d characters; %0d results checked, %0d of them successful parses.",
                 chars_sent, result_count, ok_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/itap_pkg.sv
rtl/core/itap_front.sv
rtl/core/itap_queue.sv
rtl/core/itap_back.sv
rtl/core/ipv6_text_address_parser.sv
tb/ipv6_text_address_checker.sv
tb/tb_ipv6_text_address_parser.sv
